/* sv/ring_buffer_deque_defines.svh */
// Assertion macros used by the deque datapath (rbd_dp).
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is ignored while reset is active.
`define RBD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ring_buffer_deque assertion failed");
// Clocked assertion that must also hold during reset.
`define RBD_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ring_buffer_deque assertion failed");
`else
`define RBD_ASSERT(lbl, clk, rst_n, prop)
`define RBD_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

/* sv/rbd_pkg.sv */
`default_nettype none

package rbd_pkg;

	// Storage geometry.
	localparam int CAPACITY = 16;
	localparam int ELEM_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = IDX_W + 1;

	// Field widths on the stream ports.
	localparam int CMD_W    = 2;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int M_DATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_POP_FRONT  = 2'd1,
		CMD_PUSH_BACK  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE      = 2'd0,
		STS_OVERFLOW  = 2'd1,
		STS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_pop;
	} dp_ctrl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic pop_ok;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* sv/rbd_ram.sv */
`default_nettype none

module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* sv/rbd_ctrl.sv */
`default_nettype none

module rbd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire rbd_pkg::dp_stat_t stat,
	output rbd_pkg::dp_ctrl_t     ctrl
);

	import rbd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					state_nxt = stat.pop_ok ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		s_tready      = 1'b0;
		ctrl.capture  = 1'b0;
		ctrl.exec     = 1'b0;
		ctrl.load_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				ctrl.capture = s_tvalid;
			end
			ST_EXEC: begin
				ctrl.exec = stat.out_free;
			end
			ST_READ: begin
				ctrl.load_pop = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/rbd_dp.sv */
`default_nettype none

`include "ring_buffer_deque_defines.svh"

module rbd_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rbd_pkg::dp_ctrl_t            ctrl,
	output rbd_pkg::dp_stat_t                 stat,
	input  wire logic [rbd_pkg::CMD_W-1:0]    in_cmd,
	input  wire logic [rbd_pkg::DATA_W-1:0]   in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [rbd_pkg::DATA_W-1:0]        out_data,
	output logic [rbd_pkg::STATUS_W-1:0]      out_status,
	output logic [rbd_pkg::OCC_W-1:0]         out_occ
);

	import rbd_pkg::*;

	// Captured request.
	cmd_t              cmd_q;
	logic [ELEM_W-1:0] data_q;

	// Deque bookkeeping.
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;

	// Result register.
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_data_q;
	status_t             out_status_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic              is_push;
	logic              full;
	logic              empty;
	logic              push_ok;
	logic              pop_ok;
	logic [IDX_W-1:0]  front_dec;
	logic [IDX_W-1:0]  front_inc;
	logic [CNT_W-1:0]  offset;
	logic [SUM_W-1:0]  sum;
	logic [IDX_W-1:0]  slot;
	logic [IDX_W-1:0]  addr;
	logic [IDX_W-1:0]  front_nxt;
	logic [CNT_W-1:0]  count_nxt;
	status_t           direct_status;
	logic [ELEM_W-1:0] rd_data;

	// Capture the request fields on acceptance.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= cmd_t'(in_cmd);
			data_q <= in_data[ELEM_W-1:0];
		end
	end

	// Full and empty tests.
	assign is_push = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign push_ok = is_push && !full;
	assign pop_ok  = !is_push && !empty;

	// Wrapped neighbors of the front index.
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;

	// Back slot: front plus count, or front plus count minus one, wrapped once.
	assign offset = (cmd_q == CMD_PUSH_BACK) ? count_q : count_q - 1'b1;
	assign sum    = {1'b0, front_q} + SUM_W'(offset);
	assign slot   = (sum >= SUM_W'(CAPACITY)) ? IDX_W'(sum - SUM_W'(CAPACITY))
		: sum[IDX_W-1:0];

	// Store address for the current command.
	always_comb begin
		case (cmd_q)
			CMD_PUSH_FRONT: addr = front_dec;
			CMD_POP_FRONT:  addr = front_q;
			default:        addr = slot;
		endcase
	end

	// Next front index and count.
	always_comb begin
		front_nxt = front_q;
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + 1'b1;
			if (cmd_q == CMD_PUSH_FRONT) begin
				front_nxt = front_dec;
			end
		end else if (pop_ok) begin
			count_nxt = count_q - 1'b1;
			if (cmd_q == CMD_POP_FRONT) begin
				front_nxt = front_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (ctrl.exec) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// Element store.
	rbd_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (ctrl.exec && push_ok),
		.wr_addr (addr),
		.wr_data (data_q),
		.rd_en   (ctrl.exec && pop_ok),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	// Status for results that need no store read.
	always_comb begin
		case (cmd_q) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: direct_status = full ? STS_OVERFLOW : STS_DONE;
			default:                       direct_status = STS_UNDERFLOW;
		endcase
	end

	// Result register: loaded directly or from the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.exec && !pop_ok) || ctrl.load_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec && !pop_ok) begin
			out_data_q   <= '0;
			out_status_q <= direct_status;
			out_occ_q    <= OCC_W'(count_nxt);
		end else if (ctrl.load_pop) begin
			out_data_q   <= DATA_W'(rd_data);
			out_status_q <= STS_DONE;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;
	assign out_occ    = out_occ_q;
	assign stat       = '{pop_ok: pop_ok, out_free: (!out_valid_q || out_ready)};

	// The count never leaves its range.
	`RBD_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	// A result is only loaded when the result register can take it.
	`RBD_ASSERT(a_load_when_free, clk, arst_n, (ctrl.exec || ctrl.load_pop) |-> stat.out_free)
	// A successful pop removes exactly one element.
	`RBD_ASSERT(a_pop_count, clk, arst_n, (ctrl.exec && pop_ok) |=> (count_q == $past(count_q) - 1'b1))
	// Executing and loading a read result never coincide.
	`RBD_ASSERT_NORST(a_exec_load_excl, clk, !(ctrl.exec && ctrl.load_pop))

endmodule

`default_nettype wire

/* sv/ring_buffer_deque.sv */
// Circular double-ended queue of 16 elements of 32 bits. Each request on the
// slave stream carries a command in s_tuser (push front, pop front, push back,
// pop back) and the element in s_tdata; every request yields exactly one
// result on the master stream with the popped element (zero for pushes and
// refused pops), the status in m_tuser (done, overflow, underflow) and the
// occupancy after the command. A push into a full queue or a pop from an
// empty one is refused and changes nothing. A push or a refused command
// reaches the result register from the execute state after its acceptance,
// and a successful pop from the read state after that, as the element store
// has a registered read port; the controller takes one request at a time and
// accepts none until the last has reached the result register. That register
// lets the next request be accepted while a result still waits; a result held
// longer by m_tready delays the next request's execution.
`default_nettype none

module ring_buffer_deque (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// s_tdata: push_data[31:0]
	input  wire logic [rbd_pkg::DATA_W-1:0]       s_tdata,
	// s_tuser: command[1:0]
	input  wire logic [rbd_pkg::CMD_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata: pop_data[31:0], occupancy[36:32], zero[39:37]
	output logic [rbd_pkg::M_DATA_W-1:0]          m_tdata,
	// m_tuser: status[1:0]
	output logic [rbd_pkg::STATUS_W-1:0]          m_tuser
);

	import rbd_pkg::*;

	dp_ctrl_t          ctrl;
	dp_stat_t          stat;
	logic [DATA_W-1:0] pop_data;
	logic [OCC_W-1:0]  occupancy;

	// Sequencing of one request at a time.
	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Indices, element store and result register.
	rbd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.in_cmd     (s_tuser),
		.in_data    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (pop_data),
		.out_status (m_tuser),
		.out_occ    (occupancy)
	);

	// Pack the result fields.
	assign m_tdata = {(M_DATA_W - DATA_W - OCC_W)'(0), occupancy, pop_data};

endmodule

`default_nettype wire
